/* rtl/bbn_pkg.sv */
// ----------------------------------------------------------------------------
// bbn_pkg: shared types and constants for the 3x3 box blur.
// Holds the payload structs, the opcode names and the queue entry type.
// ----------------------------------------------------------------------------
package bbn_pkg;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam int CFG_WIDTH_IDX  = 0;
	localparam int CFG_HEIGHT_IDX = 1;
	localparam int CFG_DW         = 16;
	localparam int CFG_AW         = 1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} bbn_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       frame_last;
	} bbn_out_t;

	// Classified window, handed from the front to the back.
	// Sums are at most 9*255 = 2295, which fits 12 bits.
	typedef struct packed {
		logic [11:0] sum_r;
		logic [11:0] sum_g;
		logic [11:0] sum_b;
		logic [3:0]  cnt;
		logic        last;
	} bbn_job_t;

endpackage

/* rtl/bbn_front.sv */
// ----------------------------------------------------------------------------
// bbn_front: line buffers, 3x3 window and neighbourhood sums.
// Accepts items, tracks frame position, emits one job per due result.
// ----------------------------------------------------------------------------
module bbn_front import bbn_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_AW-1:0]    cfg_idx,
	input  logic [CFG_DW-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bbn_in_t              in_data,
	output logic                 job_valid,
	output bbn_job_t             job,
	input  logic                 q_room
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [WW-1:0] w_eff;
	logic [15:0]   h_eff;

	always_comb begin
		if (width_q == '0) w_eff = WW'(1);
		else if ({21'd0, width_q} > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(width_q);
		h_eff = (height_q == '0) ? 16'd1 : height_q;
	end

	// Frame position: input column, startup count, result row/col.
	logic [CW-1:0] icol_q;
	logic [WW:0]   prime_q;
	logic          active_q;
	logic [WW-1:0] rc_q;
	logic [15:0]   rr_q;

	logic acc, drain, live, prime_done;
	assign in_stall = !q_room;
	assign acc = in_valid && !in_stall;
	assign drain = in_data.opcode == OP_DRAIN;
	assign live = acc && !(drain && !active_q);
	assign prime_done = prime_q == {1'b0, w_eff} + (WW+1)'(1);

	logic [23:0] pix;
	assign pix = drain ? 24'd0 : {in_data.in_red, in_data.in_green, in_data.in_blue};

	// Line stores, read and written at the input column.
	logic [23:0] mem2 [MAX_WIDTH];
	logic [23:0] mem1 [MAX_WIDTH];
	logic [23:0] up2_s1, up1_s1, pix_s1;
	logic        v_s1, due_s1;

	always_ff @(posedge clk) begin
		if (live) begin
			up2_s1 <= mem2[icol_q];
			up1_s1 <= mem1[icol_q];
			mem2[icol_q] <= mem1[icol_q];
			mem1[icol_q] <= pix;
			pix_s1 <= pix;
		end
	end

	// Position control.
	logic frame_end;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd1; height_q <= 16'd1;
			icol_q <= '0; prime_q <= '0; active_q <= 1'b0;
			rc_q <= '0; rr_q <= '0; v_s1 <= 1'b0; due_s1 <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_AW'(CFG_WIDTH_IDX)) width_q <= cfg_data[10:0];
			else height_q <= cfg_data;
			icol_q <= '0; prime_q <= '0; active_q <= 1'b0;
			rc_q <= '0; rr_q <= '0; v_s1 <= 1'b0;
		end else begin
			v_s1 <= live;
			due_s1 <= live && prime_done;
			if (live) begin
				active_q <= 1'b1;
				icol_q <= ({1'b0, icol_q} + 1'b1 == (CW+1)'(w_eff)) ? '0 : icol_q + 1'b1;
				if (!prime_done) prime_q <= prime_q + 1'b1;
				if (prime_done) begin
					if (frame_end) begin
						icol_q <= '0; prime_q <= '0; active_q <= 1'b0;
						rc_q <= '0; rr_q <= '0;
					end else if (rc_q + 1'b1 == w_eff) begin
						rc_q <= '0; rr_q <= rr_q + 1'b1;
					end else rc_q <= rc_q + 1'b1;
				end
			end
		end
	end
	assign frame_end = (rc_q + 1'b1 == w_eff) && (rr_q + 1'b1 == h_eff);

	// Window shift and edge flags of the due result.
	logic [23:0] win_q [9];
	logic top_s1, bot_s1, lft_s1, rgt_s1, last_s1;
	always_ff @(posedge clk) begin
		if (live) begin
			top_s1 <= rr_q == '0;
			bot_s1 <= rr_q + 1'b1 >= h_eff;
			lft_s1 <= rc_q == '0;
			rgt_s1 <= rc_q + 1'b1 >= w_eff;
			last_s1 <= frame_end;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (v_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i*3]   <= win_q[i*3+1];
				win_q[i*3+1] <= win_q[i*3+2];
			end
			win_q[2] <= up2_s1; win_q[5] <= up1_s1; win_q[8] <= pix_s1;
		end
	end

	// The window after the shift in this cycle feeds the sum.
	logic [23:0] nw [9];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nw[i*3] = win_q[i*3+1]; nw[i*3+1] = win_q[i*3+2];
		end
		nw[2] = up2_s1; nw[5] = up1_s1; nw[8] = pix_s1;
	end

	always_comb begin
		job = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (!((i == 0 && top_s1) || (i == 2 && bot_s1) ||
					(j == 0 && lft_s1) || (j == 2 && rgt_s1))) begin
					job.sum_r = job.sum_r + 12'(nw[i*3+j][23:16]);
					job.sum_g = job.sum_g + 12'(nw[i*3+j][15:8]);
					job.sum_b = job.sum_b + 12'(nw[i*3+j][7:0]);
					job.cnt = job.cnt + 4'd1;
				end
			end
		end
		job.last = last_s1;
	end
	assign job_valid = v_s1 && due_s1;
endmodule

/* rtl/bbn_queue.sv */
// ----------------------------------------------------------------------------
// bbn_queue: four-entry FIFO between front and back.
// Room is reported with two spare slots so in-flight jobs always fit.
// ----------------------------------------------------------------------------
module bbn_queue import bbn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  bbn_job_t wdata,
	output logic     room,
	output logic     rd_valid,
	input  logic     rd,
	output bbn_job_t rdata
);
	bbn_job_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign room = cnt_q <= 3'd1;
	assign rd_valid = cnt_q != '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end
endmodule

/* rtl/bbn_back.sv */
// ----------------------------------------------------------------------------
// bbn_back: rounded division of the sums and the output register.
// Divides by 1..9 with a small reciprocal table per channel.
// ----------------------------------------------------------------------------
module bbn_back import bbn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	input  bbn_job_t job,
	output logic     job_take,
	output logic     out_valid,
	input  logic     out_stall,
	output bbn_out_t out_data
);
	// Reciprocal of the count scaled by 2^16, rounded up.
	function automatic logic [16:0] recip(input logic [3:0] c);
		case (c)
			4'd1:    recip = 17'd65536;
			4'd2:    recip = 17'd32768;
			4'd3:    recip = 17'd21846;
			4'd4:    recip = 17'd16384;
			4'd5:    recip = 17'd13108;
			4'd6:    recip = 17'd10923;
			4'd7:    recip = 17'd9363;
			4'd8:    recip = 17'd8192;
			4'd9:    recip = 17'd7282;
			default: recip = 17'd0;
		endcase
	endfunction

	// Round half up: (2s + c) div 2c equals (s + c/2) div c. The scaled
	// reciprocal gives the exact quotient for any numerator below 4096.
	function automatic logic [7:0] rdiv(input logic [11:0] s, input logic [3:0] c);
		logic [11:0] m;
		logic [28:0] p;
		m = s + 12'(c[3:1]);
		p = 29'(m) * 29'(recip(c));
		return p[23:16];
	endfunction

	assign job_take = job_valid && (!out_valid || !out_stall);

	always_ff @(posedge clk) begin
		if (job_take) begin
			out_data.out_red <= rdiv(job.sum_r, job.cnt);
			out_data.out_green <= rdiv(job.sum_g, job.cnt);
			out_data.out_blue <= rdiv(job.sum_b, job.cnt);
			out_data.frame_last <= job.last;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (job_take) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end
endmodule

/* rtl/box_blur_3x3_edge_normalized.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_normalized: 3x3 RGB box blur, edge-normalized divisor.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | bbn_in_t: opcode, in_red/green/blue
//  out     | out_valid/out_stall| bbn_out_t: out_red/green/blue, frame_last
//  cfg     | cfg_we             | cfg_idx, cfg_data
//
// One item per clock while in_stall is low. The result that an item triggers
// passes line-store read, window sum into the job queue, divide into the
// output register; out_stall can hold it in the queue.
// Reset clears counters and window; line stores are not cleared.
// in_stall rises when the four-entry job queue has fewer than three free slots.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_normalized import bbn_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_idx,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  bbn_in_t           in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output bbn_out_t          out_data
);
	logic jv, room, qv, take;
	bbn_job_t jb, qd;

	bbn_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .in_valid, .in_stall,
		.in_data, .job_valid(jv), .job(jb), .q_room(room));
	bbn_queue u_queue (
		.clk, .arst_n, .wr(jv), .wdata(jb), .room, .rd_valid(qv), .rd(take),
		.rdata(qd));
	bbn_back u_back (
		.clk, .arst_n, .job_valid(qv), .job(qd), .job_take(take),
		.out_valid, .out_stall, .out_data);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	a_take_ok: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> qv)
		else $error("queue read while empty");
	a_cnt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		jv |-> jb.cnt != 4'd0)
		else $error("job with empty neighbourhood");
endmodule
